>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define TCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold.
`define TCW_NEVER(lbl, clk, rstn, cond, msg) \
  `TCW_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

>>> rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  localparam logic [7:0] NEWLINE_CODE       = 8'd10;
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_WIPE,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_COPY,
    ST_DRAIN,
    ST_CLR
  } state_t;

  typedef enum logic [1:0] {
    SWP_ZERO,
    SWP_COLS,
    SWP_LASTROW
  } swp_sel_t;

  typedef struct packed {
    logic     capture;
    logic     exec;
    logic     copy_en;
    logic     zero_en;
    logic     swp_load;
    swp_sel_t swp_sel;
    logic     emit;
    logic     emit_scrolled;
  } tcw_cmd_t;

  typedef struct packed {
    logic it_read;
    logic need_scroll;
    logic swp_last;
  } tcw_status_t;

endpackage

>>> rtl/core/text_console_writer_unit.sv
// Text console screen store of COLS x ROWS 16-bit cells (character low byte,
// attribute high byte) with a cursor. Pulse start while busy is low to issue one
// command; exactly one result follows, shown for a single cycle under out_strobe,
// and the receiver cannot stall it, so it must take every beat as it comes. A
// print that does not scroll goes back to idle from its execute state, a read
// from a data state after one registered read of the cell memory. A print that
// scrolls copies COLS*(ROWS-1) cells through the single write port of the cell
// memory, then clears the last row. After reset the block clears every cell,
// one per cycle, and stays busy until the last one is clear.
// cfg_we may be written at any time the block is idle.
module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::COLS_DEFAULT,
  parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_mode,
  input  logic [7:0] in_character,
  input  logic [6:0] in_col,
  input  logic [4:0] in_row,
  input  logic       in_at_cursor,
  input  logic [7:0] in_attribute,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic       out_strobe,
  output logic [6:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic       out_scrolled,
  output logic [7:0] out_read_char,
  output logic [7:0] out_read_attribute
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t sts;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_character       (in_character),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_at_cursor       (in_at_cursor),
    .in_attribute       (in_attribute),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_strobe         (out_strobe),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_row     (out_cursor_row),
    .out_scrolled       (out_scrolled),
    .out_read_char      (out_read_char),
    .out_read_attribute (out_read_attribute)
  );

`include "assert_macros.svh"

  `TCW_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "back-to-back result beats")
  `TCW_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accepted beat left block idle")
  `TCW_ASSERT(a_scroll_cursor, clk, rst_n, out_strobe && out_scrolled |-> out_cursor_col == 7'd0 && out_cursor_row == 5'(ROWS - 1), "scroll left cursor off last row start")

endmodule

>>> rtl/core/tcw_ctrl.sv
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcw_pkg::tcw_status_t sts,
  output tcw_pkg::tcw_cmd_t   cmd
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  state_nxt = ST_WIPE;
      ST_WIPE:  if (sts.swp_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.it_read) state_nxt = ST_RDATA;
        else if (sts.need_scroll) state_nxt = ST_COPY;
        else state_nxt = ST_IDLE;
      end
      ST_RDATA: state_nxt = ST_IDLE;
      ST_COPY:  if (sts.swp_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_CLR;
      ST_CLR:   if (sts.swp_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.swp_load = 1'b1;
        cmd.swp_sel  = SWP_ZERO;
      end
      ST_WIPE:  cmd.zero_en = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.it_read && sts.need_scroll) begin
          cmd.swp_load = 1'b1;
          cmd.swp_sel  = SWP_COLS;
        end
        cmd.emit = !sts.it_read && !sts.need_scroll;
      end
      ST_RDATA: cmd.emit = 1'b1;
      ST_COPY:  cmd.copy_en = 1'b1;
      ST_DRAIN: begin
        cmd.swp_load = 1'b1;
        cmd.swp_sel  = SWP_LASTROW;
      end
      ST_CLR: begin
        cmd.zero_en       = 1'b1;
        cmd.emit          = sts.swp_last;
        cmd.emit_scrolled = sts.swp_last;
      end
      default: cmd = '0;
    endcase
  end

`include "assert_macros.svh"

  `TCW_NEVER(a_capture_busy, clk, rst_n, cmd.capture && state_r != ST_IDLE, "capture while busy")
  `TCW_ASSERT(a_copy_drain, clk, rst_n, state_r == ST_COPY && sts.swp_last |=> state_r == ST_DRAIN, "copy did not drain")
  `TCW_NEVER(a_wr_overlap, clk, rst_n, cmd.copy_en && cmd.zero_en, "copy and clear overlap")

endmodule

>>> rtl/core/tcw_datapath.sv
module tcw_datapath #(
  parameter int COLS = tcw_pkg::COLS_DEFAULT,
  parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_pkg::tcw_cmd_t    cmd,
  output tcw_pkg::tcw_status_t sts,
  input  logic                 in_mode,
  input  logic [7:0]           in_character,
  input  logic [6:0]           in_col,
  input  logic [4:0]           in_row,
  input  logic                 in_at_cursor,
  input  logic [7:0]           in_attribute,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  output logic                 out_strobe,
  output logic [6:0]           out_cursor_col,
  output logic [4:0]           out_cursor_row,
  output logic                 out_scrolled,
  output logic [7:0]           out_read_char,
  output logic [7:0]           out_read_attribute
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = $clog2(CELLS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;

  logic [7:0]    dflt_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] cur_row_r;

  logic          it_mode_r, it_atc_r;
  logic [7:0]    it_ch_r, it_attr_r;
  logic [CW-1:0] it_col_r;
  logic [RW-1:0] it_row_r;

  logic [AW-1:0] swp_r;
  logic [AW-1:0] cp_wa_r;
  logic          cp_wv_r;

  logic          strobe_r, scrolled_r;
  logic [7:0]    rchar_r, rattr_r;

  logic [CW-1:0] col_sat, pc, col_nxt;
  logic [RW-1:0] row_sat, pr, row_nxt;
  logic [AW-1:0] cell_addr, rd_addr;
  logic [7:0]    attr_eff;
  logic          is_nl, wrap, last_row, print_wr;

  assign col_sat = ({1'b0, in_col} > 8'(COLS - 1)) ? CW'(COLS - 1) : CW'(in_col);
  assign row_sat = ({2'b0, in_row} > 7'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(in_row);

  assign pc        = (!it_mode_r && it_atc_r) ? cur_col_r : it_col_r;
  assign pr        = (!it_mode_r && it_atc_r) ? cur_row_r : it_row_r;
  assign cell_addr = AW'(AW'(pr) * AW'(COLS)) + AW'(pc);
  assign attr_eff  = (it_attr_r == 8'd0) ? dflt_r : it_attr_r;
  assign is_nl     = (it_ch_r == NEWLINE_CODE);
  assign wrap      = is_nl || (pc == CW'(COLS - 1));
  assign last_row  = (pr == RW'(ROWS - 1));
  assign col_nxt   = wrap ? '0 : CW'(pc + CW'(1));
  assign row_nxt   = !wrap ? pr : (last_row ? RW'(ROWS - 1) : RW'(pr + RW'(1)));
  assign print_wr  = cmd.exec && !it_mode_r && !is_nl;
  assign rd_addr   = cmd.copy_en ? swp_r : cell_addr;

  assign sts.it_read     = it_mode_r;
  assign sts.need_scroll = wrap && last_row;
  assign sts.swp_last    = (swp_r == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (cp_wv_r) begin
      mem[cp_wa_r] <= rdata_r;
    end else if (cmd.zero_en) begin
      mem[swp_r] <= '0;
    end else if (print_wr) begin
      mem[cell_addr] <= {attr_eff, it_ch_r};
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode_r <= in_mode;
      it_ch_r   <= in_character;
      it_col_r  <= col_sat;
      it_row_r  <= row_sat;
      it_atc_r  <= in_at_cursor;
      it_attr_r <= in_attribute;
    end
    if (cmd.swp_load) begin
      case (cmd.swp_sel)
        SWP_ZERO:    swp_r <= '0;
        SWP_COLS:    swp_r <= AW'(COLS);
        SWP_LASTROW: swp_r <= AW'(CELLS - COLS);
        default:     swp_r <= '0;
      endcase
    end else if (cmd.copy_en || cmd.zero_en) begin
      swp_r <= AW'(swp_r + AW'(1));
    end
    cp_wa_r <= AW'(swp_r - AW'(COLS));
    if (cmd.emit) begin
      scrolled_r <= cmd.emit_scrolled;
      rchar_r    <= it_mode_r ? rdata_r[7:0]  : 8'd0;
      rattr_r    <= it_mode_r ? rdata_r[15:8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r    <= DEFAULT_ATTR_RESET;
      cur_col_r <= '0;
      cur_row_r <= '0;
      cp_wv_r   <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      if (cfg_we) dflt_r <= cfg_wdata;
      if (cmd.exec && !it_mode_r) begin
        cur_col_r <= col_nxt;
        cur_row_r <= row_nxt;
      end
      cp_wv_r  <= cmd.copy_en;
      strobe_r <= cmd.emit;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_cursor_col     = 7'(cur_col_r);
  assign out_cursor_row     = 5'(cur_row_r);
  assign out_scrolled       = scrolled_r;
  assign out_read_char      = rchar_r;
  assign out_read_attribute = rattr_r;

endmodule

>>> dv/text_console_writer_unit_tb.sv
module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int COLS = COLS_DEFAULT;
  localparam int ROWS = ROWS_DEFAULT;
  localparam int CELLS = COLS * ROWS;
  localparam int N_PHASES = 4;
  localparam int RAND_PER_PHASE = 370;
  localparam longint CYCLE_LIMIT =
    longint'(4) * (N_PHASES * RAND_PER_PHASE + 100) * (CELLS + 40) + 20 * CELLS;

  localparam logic MODE_PRINT = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    logic       at_cursor;
    logic [7:0] attr;
  } console_cmd_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } console_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_mode = 1'b0;
  logic [7:0] in_character = '0;
  logic [6:0] in_col = '0;
  logic [4:0] in_row = '0;
  logic       in_at_cursor = 1'b0;
  logic [7:0] in_attribute = '0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       out_strobe;
  logic [6:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic       out_scrolled;
  logic [7:0] out_read_char;
  logic [7:0] out_read_attribute;

  console_cmd_t    cmd_q[$];
  console_result_t cursor_result_q[$];
  logic [15:0]     screen_image[CELLS];
  int unsigned     cursor_pos;
  logic [7:0]      default_attr;
  int              idle_pct = 0;
  logic            took_beat = 1'b0;
  int              errors = 0;
  longint          cycles = 0;

  text_console_writer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_character(in_character),
    .in_col(in_col),
    .in_row(in_row),
    .in_at_cursor(in_at_cursor),
    .in_attribute(in_attribute),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_scrolled(out_scrolled),
    .out_read_char(out_read_char),
    .out_read_attribute(out_read_attribute)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned cell_index(logic [6:0] col, logic [4:0] row);
    int unsigned c;
    int unsigned r;
    c = (col > COLS - 1) ? COLS - 1 : col;
    r = (row > ROWS - 1) ? ROWS - 1 : row;
    return r * COLS + c;
  endfunction

  function automatic console_result_t console_step(console_cmd_t c);
    console_result_t r;
    int unsigned     pos;
    logic [15:0]     cell_word;
    logic [7:0]      a;
    r = '0;
    if (c.mode == MODE_READ) begin
      cell_word = screen_image[cell_index(c.col, c.row)];
      r.read_char = cell_word[7:0];
      r.read_attr = cell_word[15:8];
    end else begin
      pos = c.at_cursor ? cursor_pos : cell_index(c.col, c.row);
      a = (c.attr == 8'd0) ? default_attr : c.attr;
      if (c.ch == NEWLINE_CODE) begin
        pos = (pos / COLS) * COLS + COLS - 1;
      end else begin
        screen_image[pos] = {a, c.ch};
      end
      pos++;
      if (pos >= CELLS) begin
        for (int i = 0; i < CELLS - COLS; i++) screen_image[i] = screen_image[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen_image[i] = '0;
        pos = CELLS - COLS;
        r.scrolled = 1'b1;
      end
      cursor_pos = pos;
    end
    r.cursor_col = 7'(cursor_pos % COLS);
    r.cursor_row = 5'(cursor_pos / COLS);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void queue_cmd(logic mode, logic [7:0] ch, logic [6:0] col,
                                    logic [4:0] row, logic at_cursor, logic [7:0] attr);
    cmd_q.push_back('{mode, ch, col, row, at_cursor, attr});
  endfunction

  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int unsigned  pick;
    c = console_cmd_t'($urandom);
    pick = $urandom_range(99);
    c.attr = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(255));
    c.col = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(COLS - 1));
    c.row = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(ROWS - 1));
    if (pick < 25) begin
      c.mode = MODE_READ;
    end else begin
      c.mode = MODE_PRINT;
      c.at_cursor = (pick < 60);
      c.ch = ($urandom_range(99) < 8) ? NEWLINE_CODE : 8'($urandom_range(255));
    end
    return c;
  endfunction

  always @(negedge clk) begin
    logic         go;
    console_cmd_t c;
    if (took_beat) void'(cmd_q.pop_front());
    go = rst_n && (cmd_q.size() > 0) && ($urandom_range(99) >= idle_pct);
    c = go ? cmd_q[0] : console_cmd_t'($urandom);
    start <= go;
    in_mode <= c.mode;
    in_character <= c.ch;
    in_col <= c.col;
    in_row <= c.row;
    in_at_cursor <= c.at_cursor;
    in_attribute <= c.attr;
  end

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      took_beat <= rst_n && start && !busy;
      if (rst_n && out_strobe) begin
        got = '{out_cursor_col, out_cursor_row, out_scrolled, out_read_char,
                out_read_attribute};
        if (cursor_result_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, actual %p", $time, got);
        end else begin
          want = cursor_result_q.pop_front();
          check_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
          check_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
          check_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
          check_field("read_char", want.read_char, got.read_char);
          check_field("read_attribute", want.read_attr, got.read_attr);
        end
      end
      if (rst_n && start && !busy) begin
        cursor_result_q.push_back(console_step('{in_mode, in_character, in_col, in_row,
                                                 in_at_cursor, in_attribute}));
      end
    end
  end

  initial begin
    int         phase_idle[N_PHASES];
    logic [7:0] cfg_vals[N_PHASES];
    foreach (screen_image[i]) screen_image[i] = '0;
    cursor_pos = 0;
    default_attr = DEFAULT_ATTR_RESET;
    phase_idle = '{0, 65, 0, 29};
    cfg_vals = '{8'd255, 8'd0, 8'd255, 8'($urandom_range(1, 254))};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < N_PHASES; phase++) begin
      while (busy || cmd_q.size() > 0 || cursor_result_q.size() > 0) @(negedge clk);
      cfg_wdata <= cfg_vals[phase];
      cfg_we <= 1'b1;
      @(negedge clk);
      cfg_we <= 1'b0;
      default_attr = cfg_vals[phase];
      idle_pct = phase_idle[phase];
      if (phase == 1) begin
        queue_cmd(MODE_PRINT, 8'd0, 7'd0, 5'd0, 1'b0, 8'd0);
        queue_cmd(MODE_READ, 8'd0, 7'd0, 5'd0, 1'b0, 8'd0);
        queue_cmd(MODE_PRINT, 8'd255, 7'd127, 5'd31, 1'b0, 8'd255);
        queue_cmd(MODE_READ, 8'd0, 7'd79, 5'd23, 1'b0, 8'd0);
        queue_cmd(MODE_READ, 8'd0, 7'd127, 5'd31, 1'b0, 8'd0);
        queue_cmd(MODE_PRINT, 8'h41, 7'd0, 5'd0, 1'b1, 8'h70);
        queue_cmd(MODE_PRINT, NEWLINE_CODE, 7'd0, 5'd0, 1'b1, 8'h07);
        queue_cmd(MODE_READ, 8'd255, 7'd0, 5'd23, 1'b1, 8'd255);
        queue_cmd(MODE_PRINT, NEWLINE_CODE, 7'd5, 5'd3, 1'b0, 8'd0);
        queue_cmd(MODE_PRINT, 8'd1, 7'd127, 5'd31, 1'b1, 8'd1);
        queue_cmd(MODE_READ, 8'd0, 7'd0, 5'd4, 1'b0, 8'd0);
        queue_cmd(MODE_PRINT, 8'h7f, 7'd79, 5'd0, 1'b0, 8'h80);
        queue_cmd(MODE_READ, 8'd0, 7'd127, 5'd0, 1'b0, 8'd0);
        queue_cmd(MODE_PRINT, NEWLINE_CODE, 7'd0, 5'd31, 1'b0, 8'd0);
        queue_cmd(MODE_READ, 8'd0, 7'd127, 5'd0, 1'b0, 8'd0);
        queue_cmd(MODE_PRINT, 8'd255, 7'd0, 5'd0, 1'b1, 8'd255);
        queue_cmd(MODE_READ, 8'd0, 7'd0, 5'd24, 1'b0, 8'd0);
        queue_cmd(MODE_READ, 8'd0, 7'd0, 5'd0, 1'b0, 8'd0);
      end
      repeat (RAND_PER_PHASE) cmd_q.push_back(random_cmd());
    end
    while (cmd_q.size() > 0 || cursor_result_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && cursor_result_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (cursor_result_q.size() > 0)
        $display("%0t: %0d expected results never arrived", $time, cursor_result_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer_unit.sv
dv/text_console_writer_unit_tb.sv
